>>> design/efj_pkg.sv
package efj_pkg;

  typedef logic signed [31:0] fx_t;
  typedef logic signed [63:0] prod_t;
  typedef logic signed [35:0] ratio_t;
  typedef logic [2:0]         col_t;

  localparam int   NUM_COL  = 5;
  localparam int   NUM_ROW  = 5;
  localparam col_t LAST_COL = 3'd4;

  // gamma - 1, (gamma - 1) / 2 and gamma in Q16.16
  localparam fx_t FX_K      = 32'sd26214;
  localparam fx_t FX_HALF_K = 32'sd13107;
  localparam fx_t FX_GAMMA  = 32'sd91750;

  localparam prod_t FX_MAX = 64'sd2147483647;
  localparam prod_t FX_MIN = -64'sd2147483648;

  // pressure ratio divider: quotient bits, bits per stage, stages
  localparam int DIV_BITS  = 34;
  localparam int DIV_STEPS = 2;
  localparam int DIV_ITER  = DIV_BITS / DIV_STEPS;
  localparam int DIV_LAT   = DIV_ITER + 2;
  // product stages run alongside the divider; MID_DLY holds them for the rest
  localparam int MID_DLY   = DIV_LAT - 5;

  typedef fx_t [NUM_COL-1:0][NUM_ROW-1:0] mat_t;

  typedef struct packed {
    fx_t [2:0]      n;
    fx_t            qn;
    fx_t            hq;
    fx_t [2:0][2:0] vn;
    fx_t [2:0]      kn;
    fx_t            hk;
    fx_t [2:0]      vq;
    fx_t [2:0][2:0] kvn;
    fx_t [2:0]      kvq;
    fx_t            gq;
  } mid_t;

  function automatic fx_t sat_fx(input prod_t v);
    if (v > FX_MAX) begin
      return fx_t'(FX_MAX);
    end else if (v < FX_MIN) begin
      return fx_t'(FX_MIN);
    end
    return fx_t'(v);
  endfunction

  function automatic prod_t mul_fx(input fx_t a, input fx_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

  // round half up, drop 16 fraction bits, saturate
  function automatic fx_t rnd_fx(input prod_t p);
    prod_t t;
    t = p + 64'sd32768;
    return sat_fx(t >>> 16);
  endfunction

  function automatic fx_t sum3_fx(input fx_t a, input fx_t b, input fx_t c);
    return sat_fx(prod_t'(a) + prod_t'(b) + prod_t'(c));
  endfunction

  function automatic fx_t dif_fx(input fx_t a, input fx_t b);
    return sat_fx(prod_t'(a) - prod_t'(b));
  endfunction

  function automatic fx_t dsum_fx(input fx_t a, input fx_t b, input fx_t c);
    return sat_fx(prod_t'(a) - prod_t'(b) + prod_t'(c));
  endfunction

  function automatic fx_t half_fx(input fx_t a);
    logic signed [32:0] t;
    t = a;
    t = t + 33'sd1;
    return fx_t'(t >>> 1);
  endfunction

  function automatic fx_t enth_fx(input ratio_t r, input fx_t hq);
    return sat_fx(prod_t'(r) + prod_t'(hq));
  endfunction

endpackage

>>> design/euler_flux_jacobian.sv
// Euler flux Jacobian, 3D, gamma 1.4, signed Q16.16. Each accepted item
// (density, velocity, pressure, face direction) yields five output items,
// one Jacobian column each, column 0 first, tlast on column 4. The output
// stage sends one column per cycle while m_axis_tready_i is high; the
// arithmetic pipeline accepts an item every cycle until it fills. The
// latency is set by the enthalpy term: a 17-stage pressure/density divider
// that resolves two quotient bits per stage, followed by four further stages.
module euler_flux_jacobian
  import efj_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // density, vel_x, vel_y, vel_z, pressure, normal_x, normal_y, normal_z
  input  logic [255:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // column, row_mass, row_mom_x, row_mom_y, row_mom_z, row_energy, zero pad
  output logic [167:0] m_axis_tdata_o,
  output logic         m_axis_tlast_o
);

  fx_t               rho, p;
  fx_t [2:0]         vel, n;
  logic              core_valid, core_ready;
  mat_t              core_mat;
  col_t              col;
  fx_t [NUM_ROW-1:0] rows;

  assign rho    = s_axis_tdata_i[31:0];
  assign vel[0] = s_axis_tdata_i[63:32];
  assign vel[1] = s_axis_tdata_i[95:64];
  assign vel[2] = s_axis_tdata_i[127:96];
  assign p      = s_axis_tdata_i[159:128];
  assign n[0]   = s_axis_tdata_i[191:160];
  assign n[1]   = s_axis_tdata_i[223:192];
  assign n[2]   = s_axis_tdata_i[255:224];

  efj_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .rho_i      (rho),
    .vel_i      (vel),
    .p_i        (p),
    .n_i        (n),
    .out_valid_o(core_valid),
    .out_ready_i(core_ready),
    .mat_o      (core_mat)
  );

  efj_ser u_ser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ld_valid_i(core_valid),
    .ld_ready_o(core_ready),
    .ld_mat_i  (core_mat),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .col_o     (col),
    .rows_o    (rows),
    .last_o    (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {5'b0, rows[4], rows[3], rows[2], rows[1], rows[0], col};

endmodule

>>> design/efj_div.sv
module efj_div
  import efj_pkg::*;
(
  input  logic   clk_i,
  input  logic   en_i,
  input  fx_t    rho_i,
  input  fx_t    p_i,
  output ratio_t ratio_o
);

  typedef struct packed {
    logic [32:0]         rem;
    logic [33:0]         a_lo;
    logic [DIV_BITS-1:0] q;
    logic [32:0]         b;
    logic                neg;
    logic                over;
    logic                rz;
    logic                pz;
    logic                pn;
  } div_t;

  localparam ratio_t RATIO_BIG = 36'sh4_0000_0000;

  div_t        st_q [DIV_ITER+1];
  div_t        prep;
  ratio_t      ratio_d, ratio_q;
  logic [31:0] ap, ar;
  logic [34:0] ap7_w;
  logic [33:0] ap7;
  ratio_t      qs;

  function automatic div_t div_step(input div_t s);
    div_t        r;
    logic [33:0] t;
    r = s;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t = {r.rem, r.a_lo[33]};
      r.a_lo = {r.a_lo[32:0], 1'b0};
      if (t >= {1'b0, r.b}) begin
        r.rem = 33'(t - {1'b0, r.b});
        r.q   = {r.q[DIV_BITS-2:0], 1'b1};
      end else begin
        r.rem = t[32:0];
        r.q   = {r.q[DIV_BITS-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  // numerator 7 * |p| * 2^16, divisor 2 * |rho|
  always_comb begin
    ap    = p_i[31] ? (~p_i + 32'd1) : p_i;
    ar    = rho_i[31] ? (~rho_i + 32'd1) : rho_i;
    ap7_w = ({3'b0, ap} << 3) - {3'b0, ap};
    ap7   = ap7_w[33:0];
    prep.b    = {ar, 1'b0};
    prep.rem  = {17'b0, ap7[33:18]};
    prep.a_lo = {ap7[17:0], 16'b0};
    prep.q    = '0;
    prep.neg  = p_i[31] ^ rho_i[31];
    // quotient of 2^33 or more saturates the enthalpy anyway
    prep.over = ({16'b0, ap7[33:17]} >= prep.b);
    prep.rz   = (rho_i == '0);
    prep.pz   = (p_i == '0);
    prep.pn   = p_i[31];
  end

  always_comb begin
    qs = ratio_t'({2'b0, st_q[DIV_ITER].q});
    if (st_q[DIV_ITER].rz) begin
      if (st_q[DIV_ITER].pz) begin
        ratio_d = '0;
      end else if (st_q[DIV_ITER].pn) begin
        ratio_d = -RATIO_BIG;
      end else begin
        ratio_d = RATIO_BIG;
      end
    end else if (st_q[DIV_ITER].over) begin
      ratio_d = st_q[DIV_ITER].neg ? -RATIO_BIG : RATIO_BIG;
    end else begin
      ratio_d = st_q[DIV_ITER].neg ? -qs : qs;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= prep;
      for (int k = 1; k <= DIV_ITER; k++) begin
        st_q[k] <= div_step(st_q[k-1]);
      end
      ratio_q <= ratio_d;
    end
  end

  assign ratio_o = ratio_q;

endmodule

>>> design/efj_core.sv
module efj_core
  import efj_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  fx_t       rho_i,
  input  fx_t [2:0] vel_i,
  input  fx_t       p_i,
  input  fx_t [2:0] n_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output mat_t      mat_o
);

  localparam int VLEN = 10 + MID_DLY;

  logic            en;
  logic [VLEN-1:0] v_d, v_q;

  // stage 1: input
  fx_t       c1_rho_q, c1_p_q;
  fx_t [2:0] c1_vel_q, c1_n_q;
  // stage 2: raw products
  prod_t [2:0]      c2_pvv_q, c2_pkv_q, c2_pkn_q;
  prod_t [2:0][2:0] c2_pvn_q;
  fx_t   [2:0]      c2_vel_q, c2_n_q;
  // stage 3: rounded
  fx_t [2:0]      c3_vv_q, c3_kv_q, c3_kn_q, c3_vel_q, c3_n_q;
  fx_t [2:0][2:0] c3_vn_q;
  // stage 4: speed terms
  fx_t            c4_q2_q, c4_qn_q;
  fx_t [2:0]      c4_kv_q, c4_kn_q, c4_vel_q, c4_n_q;
  fx_t [2:0][2:0] c4_vn_q;
  // stage 5: second products
  prod_t            c5_phk_q, c5_pgq_q;
  prod_t [2:0]      c5_pvq_q, c5_pkvq_q;
  prod_t [2:0][2:0] c5_pkvn_q;
  fx_t              c5_hq_q, c5_qn_q;
  fx_t [2:0]        c5_kn_q, c5_n_q;
  fx_t [2:0][2:0]   c5_vn_q;
  // stage 6 and wait for the divider
  mid_t c6_q;
  mid_t dly_q [MID_DLY];
  ratio_t ratio;
  // enthalpy stages
  mid_t        h1_mid_q, h2_mid_q, h3_mid_q;
  fx_t         h1_h_q, h1_hkh_q;
  prod_t [2:0] h2_ph_q, h2_phk_q;
  prod_t       h2_phkq_q;
  fx_t [2:0]   h3_hn_q, h3_hkn_q;
  fx_t         h3_hkhq_q;
  mat_t        mat_d, mat_q;
  fx_t         h1_h;

  assign en         = !v_q[VLEN-1] || out_ready_i;
  assign in_ready_o = en;
  assign v_d        = {v_q[VLEN-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= v_d;
    end
  end

  efj_div u_div (
    .clk_i  (clk_i),
    .en_i   (en),
    .rho_i  (c1_rho_q),
    .p_i    (c1_p_q),
    .ratio_o(ratio)
  );

  assign h1_h = enth_fx(ratio, dly_q[MID_DLY-1].hq);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mat_d[0][i+1] = dif_fx(h3_hkn_q[i], h3_mid_q.vq[i]);
      mat_d[i+1][0] = h3_mid_q.n[i];
      mat_d[i+1][4] = dif_fx(h3_hn_q[i], h3_mid_q.kvq[i]);
      mat_d[4][i+1] = h3_mid_q.kn[i];
      for (int j = 0; j < 3; j++) begin
        if (i == j) begin
          mat_d[i+1][j+1] = dsum_fx(h3_mid_q.vn[j][i], h3_mid_q.kvn[i][j], h3_mid_q.qn);
        end else begin
          mat_d[i+1][j+1] = dif_fx(h3_mid_q.vn[j][i], h3_mid_q.kvn[i][j]);
        end
      end
    end
    mat_d[0][0] = '0;
    mat_d[0][4] = h3_hkhq_q;
    mat_d[4][0] = '0;
    mat_d[4][4] = h3_mid_q.gq;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_rho_q <= rho_i;
      c1_p_q   <= p_i;
      c1_vel_q <= vel_i;
      c1_n_q   <= n_i;

      for (int i = 0; i < 3; i++) begin
        c2_pvv_q[i] <= mul_fx(c1_vel_q[i], c1_vel_q[i]);
        c2_pkv_q[i] <= mul_fx(FX_K, c1_vel_q[i]);
        c2_pkn_q[i] <= mul_fx(FX_K, c1_n_q[i]);
        for (int j = 0; j < 3; j++) begin
          c2_pvn_q[i][j] <= mul_fx(c1_vel_q[i], c1_n_q[j]);
        end
      end
      c2_vel_q <= c1_vel_q;
      c2_n_q   <= c1_n_q;

      for (int i = 0; i < 3; i++) begin
        c3_vv_q[i] <= rnd_fx(c2_pvv_q[i]);
        c3_kv_q[i] <= rnd_fx(c2_pkv_q[i]);
        c3_kn_q[i] <= rnd_fx(c2_pkn_q[i]);
        for (int j = 0; j < 3; j++) begin
          c3_vn_q[i][j] <= rnd_fx(c2_pvn_q[i][j]);
        end
      end
      c3_vel_q <= c2_vel_q;
      c3_n_q   <= c2_n_q;

      c4_q2_q  <= sum3_fx(c3_vv_q[0], c3_vv_q[1], c3_vv_q[2]);
      c4_qn_q  <= sum3_fx(c3_vn_q[0][0], c3_vn_q[1][1], c3_vn_q[2][2]);
      c4_kv_q  <= c3_kv_q;
      c4_kn_q  <= c3_kn_q;
      c4_vel_q <= c3_vel_q;
      c4_n_q   <= c3_n_q;
      c4_vn_q  <= c3_vn_q;

      c5_phk_q <= mul_fx(FX_HALF_K, c4_q2_q);
      c5_pgq_q <= mul_fx(FX_GAMMA, c4_qn_q);
      for (int i = 0; i < 3; i++) begin
        c5_pvq_q[i]  <= mul_fx(c4_vel_q[i], c4_qn_q);
        c5_pkvq_q[i] <= mul_fx(c4_kv_q[i], c4_qn_q);
        for (int j = 0; j < 3; j++) begin
          c5_pkvn_q[i][j] <= mul_fx(c4_kv_q[i], c4_n_q[j]);
        end
      end
      c5_hq_q <= half_fx(c4_q2_q);
      c5_qn_q <= c4_qn_q;
      c5_kn_q <= c4_kn_q;
      c5_n_q  <= c4_n_q;
      c5_vn_q <= c4_vn_q;

      c6_q.n  <= c5_n_q;
      c6_q.qn <= c5_qn_q;
      c6_q.hq <= c5_hq_q;
      c6_q.vn <= c5_vn_q;
      c6_q.kn <= c5_kn_q;
      c6_q.hk <= rnd_fx(c5_phk_q);
      c6_q.gq <= rnd_fx(c5_pgq_q);
      for (int i = 0; i < 3; i++) begin
        c6_q.vq[i]  <= rnd_fx(c5_pvq_q[i]);
        c6_q.kvq[i] <= rnd_fx(c5_pkvq_q[i]);
        for (int j = 0; j < 3; j++) begin
          c6_q.kvn[i][j] <= rnd_fx(c5_pkvn_q[i][j]);
        end
      end

      // hold products until the pressure ratio arrives
      dly_q[0] <= c6_q;
      for (int k = 1; k < MID_DLY; k++) begin
        dly_q[k] <= dly_q[k-1];
      end

      h1_mid_q <= dly_q[MID_DLY-1];
      h1_h_q   <= h1_h;
      h1_hkh_q <= dif_fx(dly_q[MID_DLY-1].hk, h1_h);

      h2_mid_q  <= h1_mid_q;
      h2_phkq_q <= mul_fx(h1_hkh_q, h1_mid_q.qn);
      for (int i = 0; i < 3; i++) begin
        h2_ph_q[i]  <= mul_fx(h1_h_q, h1_mid_q.n[i]);
        h2_phk_q[i] <= mul_fx(h1_mid_q.hk, h1_mid_q.n[i]);
      end

      h3_mid_q  <= h2_mid_q;
      h3_hkhq_q <= rnd_fx(h2_phkq_q);
      for (int i = 0; i < 3; i++) begin
        h3_hn_q[i]  <= rnd_fx(h2_ph_q[i]);
        h3_hkn_q[i] <= rnd_fx(h2_phk_q[i]);
      end

      mat_q <= mat_d;
    end
  end

  assign out_valid_o = v_q[VLEN-1];
  assign mat_o       = mat_q;

endmodule

>>> design/efj_ser.sv
module efj_ser
  import efj_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              ld_valid_i,
  output logic              ld_ready_o,
  input  mat_t              ld_mat_i,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output col_t              col_o,
  output fx_t [NUM_ROW-1:0] rows_o,
  output logic              last_o
);

  mat_t mat_q;
  col_t cnt_d, cnt_q;
  logic busy_d, busy_q;
  logic take, fin, load;

  assign take       = busy_q && m_ready_i;
  assign fin        = take && (cnt_q == LAST_COL);
  assign ld_ready_o = !busy_q || fin;
  assign load       = ld_valid_i && ld_ready_o;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (load) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (fin) begin
      busy_d = 1'b0;
    end else if (take) begin
      cnt_d = col_t'(cnt_q + 3'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mat_q <= ld_mat_i;
    end
  end

  assign m_valid_o = busy_q;
  assign col_o     = cnt_q;
  assign rows_o    = mat_q[cnt_q];
  assign last_o    = (cnt_q == LAST_COL);

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q <= LAST_COL)
    else $error("column counter out of range");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin && !load |=> !busy_q)
    else $error("output still valid after last column");

  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> busy_q && cnt_q == '0)
    else $error("new item does not start at first column");
`endif

endmodule
